### rtl/core/lwkd_pkg.sv
`timescale 1ns / 1ps

package lwkd_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_LEN_DEF  = 4096;
  localparam int ALPHABET_DEF = 256;

  // Fixed field widths
  localparam int CH_W  = 8;
  localparam int OUT_W = 13;
  localparam int CFG_W = 9;

  localparam logic [CFG_W-1:0] MAX_DISTINCT_RST = 9'd2;

  // Input transaction payload
  typedef struct packed {
    logic [CH_W-1:0] char_byte;
    logic            first_of_string;
    logic            last_of_string;
  } in_data_t;

  // Result transaction payload
  typedef struct packed {
    logic [OUT_W-1:0] longest_length;
    logic [OUT_W-1:0] window_length;
    logic             overflow;
    logic             final_result;
  } out_data_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHK,
    ST_LOOP,
    ST_POP_RD,
    ST_POP_CNT,
    ST_POP_WR,
    ST_APPEND,
    ST_DONE
  } state_t;

endpackage

### rtl/core/longest_window_k_distinct.sv
`timescale 1ns / 1ps

// Channel  Ports                                   Direction
// -------  --------------------------------------  ---------
// input    in_valid, in_ready, in_data             in
// result   out_valid, out_ready, out_data          out
// config   cfg_wr_en, cfg_wr_data                  in
//
// Input runs CHK, APPEND, DONE (no APPEND when the limit is zero, the string
// has overflowed or the byte is outside the alphabet); POP_RD, POP_CNT, POP_WR
// and LOOP run per window-front character popped via the single ring read port.
// Reset (rst_n low, synchronous) empties the window and sets the limit to 2.
// A finished result waits in the output register; a stalled out_ready holds
// the sequencer in its last state, and in_ready stays low until it moves on.

module longest_window_k_distinct #(
  parameter int MAX_LEN  = lwkd_pkg::MAX_LEN_DEF,
  parameter int ALPHABET = lwkd_pkg::ALPHABET_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  lwkd_pkg::in_data_t             in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output lwkd_pkg::out_data_t            out_data,
  input  logic                           cfg_wr_en,
  input  logic [lwkd_pkg::CFG_W-1:0]     cfg_wr_data
);

  localparam int PW   = $clog2(MAX_LEN);          // ring index
  localparam int LW   = $clog2(MAX_LEN + 1);      // lengths and counts
  localparam int SW   = PW + 1;                   // ring index sum
  localparam int AW   = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
  localparam int DW   = $clog2(ALPHABET + 1);     // distinct count
  localparam int CHX_W = lwkd_pkg::CH_W + 1;
  localparam int CW   = lwkd_pkg::CFG_W;

  // State registers
  lwkd_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]    max_distinct_r;
  logic [PW-1:0]    head_r, head_nxt;
  logic [LW-1:0]    len_r, len_nxt;
  logic [LW-1:0]    best_r, best_nxt;
  logic [DW-1:0]    distinct_r, distinct_nxt;
  logic             ovf_r, ovf_nxt;
  logic [ALPHABET-1:0] valid_r, valid_nxt;

  // Current transaction
  logic [lwkd_pkg::CH_W-1:0] ch_r, ch_nxt;
  logic                      last_r, last_nxt;
  logic                      in_range_r, in_range_nxt;
  logic [LW-1:0]             cnt_ch_r, cnt_ch_nxt;

  // Output register
  logic                out_valid_r, out_valid_nxt;
  lwkd_pkg::out_data_t out_data_r, out_data_nxt;

  // Memories
  logic [lwkd_pkg::CH_W-1:0] ring_mem_r [MAX_LEN];
  logic [LW-1:0]             cnt_mem_r  [ALPHABET];
  logic [lwkd_pkg::CH_W-1:0] ring_rdata_r;
  logic [LW-1:0]             cnt_rdata_r;

  logic                      ring_we;
  logic [PW-1:0]             ring_waddr;
  logic                      cnt_we;
  logic [AW-1:0]             cnt_waddr;
  logic [LW-1:0]             cnt_wdata;
  logic [AW-1:0]             cnt_raddr;

  // Helpers
  logic [AW-1:0] ch_idx;
  logic [AW-1:0] b_idx;
  logic [LW-1:0] cnt_cur;
  logic [LW-1:0] cnt_b;
  logic [SW-1:0] ring_sum;
  logic          need_pop;

  assign ch_idx  = ch_r[AW-1:0];
  assign b_idx   = ring_rdata_r[AW-1:0];
  assign cnt_cur = valid_r[ch_idx] ? cnt_rdata_r : '0;
  assign cnt_b   = valid_r[b_idx] ? cnt_rdata_r : '0;
  assign need_pop = (CW'(distinct_r) >= max_distinct_r) && (len_r != '0);

  // Append slot: (head + len) mod MAX_LEN, len below MAX_LEN here
  always_comb begin
    ring_sum = SW'(head_r) + SW'(len_r[PW-1:0]);
    if (ring_sum >= SW'(MAX_LEN)) begin
      ring_sum = ring_sum - SW'(MAX_LEN);
    end
  end

  assign in_ready  = (state_r == lwkd_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Next state and datapath control
  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    len_nxt       = len_r;
    best_nxt      = best_r;
    distinct_nxt  = distinct_r;
    ovf_nxt       = ovf_r;
    valid_nxt     = valid_r;
    ch_nxt        = ch_r;
    last_nxt      = last_r;
    in_range_nxt  = in_range_r;
    cnt_ch_nxt    = cnt_ch_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_data_nxt  = out_data_r;
    ring_we       = 1'b0;
    ring_waddr    = ring_sum[PW-1:0];
    cnt_we        = 1'b0;
    cnt_waddr     = ch_idx;
    cnt_wdata     = cnt_ch_r + LW'(1);
    cnt_raddr     = b_idx;

    case (state_r)
      lwkd_pkg::ST_IDLE: begin
        cnt_raddr = in_data.char_byte[AW-1:0];
        if (in_valid) begin
          ch_nxt       = in_data.char_byte;
          last_nxt     = in_data.last_of_string;
          in_range_nxt = CHX_W'(in_data.char_byte) < CHX_W'(ALPHABET);
          if (in_data.first_of_string) begin
            head_nxt     = '0;
            len_nxt      = '0;
            best_nxt     = '0;
            distinct_nxt = '0;
            ovf_nxt      = 1'b0;
            valid_nxt    = '0;
          end
          state_nxt = lwkd_pkg::ST_CHK;
        end
      end

      // Count of the new byte is ready; decide skip, pop or append
      lwkd_pkg::ST_CHK: begin
        cnt_ch_nxt = cnt_cur;
        if (max_distinct_r == '0 || ovf_r || !in_range_r) begin
          state_nxt = lwkd_pkg::ST_DONE;
        end else if (cnt_cur == '0 && need_pop) begin
          state_nxt = lwkd_pkg::ST_POP_RD;
        end else begin
          state_nxt = lwkd_pkg::ST_APPEND;
        end
      end

      lwkd_pkg::ST_LOOP: begin
        if (need_pop) begin
          state_nxt = lwkd_pkg::ST_POP_RD;
        end else begin
          state_nxt = lwkd_pkg::ST_APPEND;
        end
      end

      // Ring read of the front character
      lwkd_pkg::ST_POP_RD: begin
        state_nxt = lwkd_pkg::ST_POP_CNT;
      end

      // Count read of the popped byte
      lwkd_pkg::ST_POP_CNT: begin
        cnt_raddr = b_idx;
        state_nxt = lwkd_pkg::ST_POP_WR;
      end

      // Retire the front character
      lwkd_pkg::ST_POP_WR: begin
        head_nxt = (head_r == PW'(MAX_LEN - 1)) ? '0 : head_r + PW'(1);
        len_nxt  = len_r - LW'(1);
        if (cnt_b != '0) begin
          cnt_we        = 1'b1;
          cnt_waddr     = b_idx;
          cnt_wdata     = cnt_b - LW'(1);
          valid_nxt[b_idx] = 1'b1;
          if (cnt_b == LW'(1) && distinct_r != '0) begin
            distinct_nxt = distinct_r - DW'(1);
          end
        end
        state_nxt = lwkd_pkg::ST_LOOP;
      end

      lwkd_pkg::ST_APPEND: begin
        if (len_r >= LW'(MAX_LEN)) begin
          ovf_nxt = 1'b1;
        end else begin
          ring_we   = 1'b1;
          cnt_we    = 1'b1;
          cnt_waddr = ch_idx;
          cnt_wdata = cnt_ch_r + LW'(1);
          valid_nxt[ch_idx] = 1'b1;
          len_nxt   = len_r + LW'(1);
          if (cnt_ch_r == '0) begin
            distinct_nxt = distinct_r + DW'(1);
          end
          if (len_r + LW'(1) > best_r) begin
            best_nxt = len_r + LW'(1);
          end
        end
        state_nxt = lwkd_pkg::ST_DONE;
      end

      // Load the result once the output register is free
      lwkd_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          if (max_distinct_r == '0) begin
            out_data_nxt.longest_length = '0;
            out_data_nxt.window_length  = '0;
          end else begin
            out_data_nxt.longest_length = lwkd_pkg::OUT_W'(best_r);
            out_data_nxt.window_length  = lwkd_pkg::OUT_W'(len_r);
          end
          out_data_nxt.overflow     = ovf_r;
          out_data_nxt.final_result = last_r;
          state_nxt = lwkd_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = lwkd_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= lwkd_pkg::ST_IDLE;
      max_distinct_r <= lwkd_pkg::MAX_DISTINCT_RST;
      head_r         <= '0;
      len_r          <= '0;
      best_r         <= '0;
      distinct_r     <= '0;
      ovf_r          <= 1'b0;
      valid_r        <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      len_r       <= len_nxt;
      best_r      <= best_nxt;
      distinct_r  <= distinct_nxt;
      ovf_r       <= ovf_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        max_distinct_r <= cfg_wr_data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    ch_r       <= ch_nxt;
    last_r     <= last_nxt;
    in_range_r <= in_range_nxt;
    cnt_ch_r   <= cnt_ch_nxt;
    out_data_r <= out_data_nxt;
  end

  // Window ring: one write, one registered read at the front
  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem_r[ring_waddr] <= ch_r;
    end
    ring_rdata_r <= ring_mem_r[head_r];
  end

  // Per-byte occurrence counts, masked by valid_r
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem_r[cnt_waddr] <= cnt_wdata;
    end
    cnt_rdata_r <= cnt_mem_r[cnt_raddr];
  end

`ifndef NO_ASSERTIONS
  // Window never grows past the ring
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LW'(MAX_LEN))
    else $error("window length exceeds ring depth");

  // Distinct bytes cannot outnumber characters in the window
  a_distinct_le_len: assert property (@(posedge clk) disable iff (!rst_n)
    LW'(distinct_r) <= len_r)
    else $error("distinct count exceeds window length");

  // Best length tracks the window
  a_best_ge_len: assert property (@(posedge clk) disable iff (!rst_n)
    best_r >= len_r)
    else $error("best length below current window");

  // One transaction at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while busy");
`endif

endmodule
